// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the LCD text sequencer checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Next-cycle implication, switched off while reset is high.
`define CLTS_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds through reset.
`define CLTS_ASSERT_NEXT_ALWAYS(label, clk_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/clts_pkg.sv
// ----------------------------------------------------------------------------
// clts_pkg
// Types, command codes and the glyph remap table for the LCD text sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package clts_pkg;

  // Item modes
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_GOTO  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  // LCD command bytes
  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] CMD_SET_ADDR = 8'h80;
  localparam logic [7:0] LINE2_OFFSET = 8'h40;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  // Register select codes
  localparam logic RS_CMD  = 1'b0;
  localparam logic RS_DATA = 1'b1;

  localparam int MAX_BYTES = 3;

  // One item's worth of LCD bytes, sent in slot order starting at slot 0
  typedef struct packed {
    logic [1:0]                  byte_count;
    logic [MAX_BYTES-1:0]        rs;
    logic [MAX_BYTES-1:0][7:0]   data;
  } job_t;

  function automatic logic [7:0] remap_glyph(input logic [7:0] c);
    logic [7:0] g;
    case (c)
      8'hA4, 8'h84: g = 8'hE1;
      8'hB6, 8'h96: g = 8'hEF;
      8'hBC, 8'h9C: g = 8'hF5;
      8'h9F:        g = 8'hE2;
      8'hB0:        g = 8'hDF;
      8'hB5:        g = 8'hE4;
      default:      g = c;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

// File: rtl/clts_front.sv
// ----------------------------------------------------------------------------
// clts_front
// Accepts items, tracks the character counter and builds the byte list.
// ----------------------------------------------------------------------------
`default_nettype none

module clts_front
  import clts_pkg::*;
#(
  parameter int COLS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] mode,
  input  wire logic [7:0] char_code,
  input  wire logic [1:0] row,
  input  wire logic [3:0] col,
  input  wire logic       full,
  output logic            push,
  output job_t            job
);

  localparam int CW = $clog2(2 * COLS + 1);
  localparam logic [CW-1:0] COLS_C     = CW'(COLS);
  localparam logic [CW-1:0] TWO_COLS_C = CW'(2 * COLS);

  logic [CW-1:0] char_count;
  logic [CW-1:0] char_count_next;
  logic [CW-1:0] cnt_w;
  logic          push_req;
  logic          row_eff;
  logic [7:0]    glyph;
  logic          accept;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && push_req;
  assign row_eff  = (row != 2'd0);
  assign glyph    = remap_glyph(char_code);

  // Newline jumps to the next line boundary before the wrap checks
  always_comb begin
    if (char_code == CHAR_NEWLINE) begin
      if (char_count >= COLS_C && char_count < TWO_COLS_C) begin
        cnt_w = TWO_COLS_C;
      end else begin
        cnt_w = COLS_C;
      end
    end else begin
      cnt_w = char_count;
    end
  end

  always_comb begin
    job             = '0;
    push_req        = 1'b0;
    char_count_next = char_count;
    case (mode)
      MODE_WRITE: begin
        push_req = 1'b1;
        if (cnt_w == COLS_C) begin
          job.byte_count  = 2'd2;
          job.rs[0]       = RS_CMD;
          job.data[0]     = CMD_SET_ADDR | LINE2_OFFSET;
          job.rs[1]       = RS_DATA;
          job.data[1]     = glyph;
          char_count_next = cnt_w + CW'(1);
        end else if (cnt_w >= TWO_COLS_C) begin
          job.byte_count  = 2'd3;
          job.rs[0]       = RS_CMD;
          job.data[0]     = CMD_CLEAR;
          job.rs[1]       = RS_CMD;
          job.data[1]     = CMD_SET_ADDR;
          job.rs[2]       = RS_DATA;
          job.data[2]     = glyph;
          char_count_next = CW'(1);
        end else begin
          job.byte_count  = 2'd1;
          job.rs[0]       = RS_DATA;
          job.data[0]     = glyph;
          char_count_next = cnt_w + CW'(1);
        end
      end
      MODE_GOTO: begin
        push_req       = 1'b1;
        job.byte_count = 2'd1;
        job.rs[0]      = RS_CMD;
        job.data[0]    = CMD_SET_ADDR | (row_eff ? LINE2_OFFSET : 8'h00) | {4'h0, col};
        char_count_next = row_eff ? (COLS_C + CW'(col)) : CW'(col);
      end
      MODE_CLEAR: begin
        push_req        = 1'b1;
        job.byte_count  = 2'd1;
        job.rs[0]       = RS_CMD;
        job.data[0]     = CMD_CLEAR;
        char_count_next = '0;
      end
      default: begin
        // unused mode: drop the item
        push_req = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count <= '0;
    end else if (accept) begin
      char_count <= char_count_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/clts_queue.sv
// ----------------------------------------------------------------------------
// clts_queue
// Small job FIFO between the item front end and the nibble sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module clts_queue
  import clts_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  job_t      push_job,
  output logic      full,
  input  wire logic pop,
  output job_t      head_job,
  output logic      head_valid
);

  localparam int PW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [FW-1:0] fill;

  assign full       = (fill == FW'(DEPTH));
  assign head_valid = (fill != '0);
  assign head_job   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/clts_back.sv
// ----------------------------------------------------------------------------
// clts_back
// Splits each queued job into nibbles and presents them one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module clts_back
  import clts_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       head_valid,
  input  job_t            head_job,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            reg_select,
  output logic [3:0]      nibble,
  output logic            last
);

  job_t       cur;
  logic       cur_valid;
  logic [2:0] idx;
  logic       load_out;
  logic       last_nib;
  logic [1:0] byte_sel;
  logic [7:0] cur_byte;
  logic [3:0] cur_nib;

  assign load_out = !out_valid || out_ready;
  assign last_nib = (idx == ({cur.byte_count, 1'b0} - 3'd1));
  assign byte_sel = idx[2:1];
  assign cur_byte = cur.data[byte_sel];
  assign cur_nib  = idx[0] ? cur_byte[3:0] : cur_byte[7:4];

  // Take the next job as the current one sends its final nibble, or at once when no job is held
  assign pop = head_valid && (!cur_valid || (load_out && last_nib));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= cur_valid;
      end
      if (cur_valid && load_out) begin
        if (last_nib) begin
          cur_valid <= head_valid;
          idx       <= '0;
        end else begin
          idx <= idx + 3'd1;
        end
      end else if (!cur_valid) begin
        cur_valid <= head_valid;
        idx       <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head_job;
    end
    if (load_out && cur_valid) begin
      reg_select <= cur.rs[byte_sel];
      nibble     <= cur_nib;
      last       <= last_nib;
    end
  end

endmodule

`default_nettype wire

// File: rtl/char_lcd_text_sequencer.sv
// ----------------------------------------------------------------------------
// char_lcd_text_sequencer
// Turns write, goto and clear items into 4-bit LCD command and data nibbles.
// ----------------------------------------------------------------------------
// The front end takes one item per cycle while the job queue has room and
// updates the character counter at once; the nibble sequencer then sends
// each LCD byte as a high and a low nibble, one nibble per cycle while
// out_ready is high. A goto or clear gives 2 nibbles, a write 2, 4 or 6
// (line wrap and screen wrap add commands); the nibble sequencer sets the
// sustained rate. With the pipe empty, an item passes through the job queue,
// the current-job register and the output register before its first nibble
// appears. Mode 3 is taken and dropped with no nibbles.
`default_nettype none

module char_lcd_text_sequencer
  import clts_pkg::*;
#(
  parameter int COLS        = 16,
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] mode,
  input  wire logic [7:0] char_code,
  input  wire logic [1:0] row,
  input  wire logic [3:0] col,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            reg_select,
  output logic [3:0]      nibble,
  output logic            last
);

  logic push;
  logic full;
  logic pop;
  logic head_valid;
  job_t push_job;
  job_t head_job;

  clts_front #(
    .COLS(COLS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .mode     (mode),
    .char_code(char_code),
    .row      (row),
    .col      (col),
    .full     (full),
    .push     (push),
    .job      (push_job)
  );

  clts_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (full),
    .pop       (pop),
    .head_job  (head_job),
    .head_valid(head_valid)
  );

  clts_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(head_valid),
    .head_job  (head_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .reg_select(reg_select),
    .nibble    (nibble),
    .last      (last)
  );

endmodule

`default_nettype wire

// File: rtl/clts_checker.sv
// ----------------------------------------------------------------------------
// clts_checker
// Port-level checks for the LCD text sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module clts_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [1:0] mode,
  input wire logic [7:0] char_code,
  input wire logic [1:0] row,
  input wire logic [3:0] col,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       reg_select,
  input wire logic [3:0] nibble,
  input wire logic       last
);

  logic        out_take;
  logic        out_stall;
  logic        in_stall;
  logic        data_hi;
  logic        data_lo;
  logic [5:0]  out_word;
  logic [15:0] in_word;

  assign out_take  = out_valid && out_ready;
  assign out_stall = out_valid && !out_ready;
  assign in_stall  = in_valid && !in_ready;
  assign data_hi   = out_take && reg_select && !last;
  assign data_lo   = out_valid && reg_select && last;
  assign out_word  = {reg_select, nibble, last};
  assign in_word   = {mode, char_code, row, col};

  // No nibble may be offered right after reset
  `CLTS_ASSERT_NEXT_ALWAYS(a_reset_idle, clk, rst, !out_valid, "output valid after reset")

  // A stalled nibble holds
  `CLTS_ASSERT_NEXT(a_out_hold, clk, rst, out_stall, out_valid && $stable(out_word), "nibble moved")

  // A waiting item holds
  `CLTS_ASSERT_NEXT(a_in_hold, clk, rst, in_stall, in_valid && $stable(in_word), "item dropped")

  // A data byte always closes its item: its low nibble follows at once, marked last
  `CLTS_ASSERT_NEXT(a_data_pair, clk, rst, data_hi, data_lo, "data low nibble missing")

  // A full queue means the sequencer is busy, so a nibble stays on offer
  `CLTS_ASSERT_NEXT(a_full_busy, clk, rst, !in_ready, out_valid, "queue full, output idle")

endmodule

bind char_lcd_text_sequencer clts_checker u_checker (.*);

`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: LCD text sequencer testbench
// Sends write, goto, clear and unused-mode items through valid/ready with
// random gaps and output stalls. Predicts the command and data nibbles from
// a local character counter and checks every nibble in order.
// ----------------------------------------------------------------------------

module tb;
  import clts_pkg::*;

  localparam int COLS = 16;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic       rs;
    logic [3:0] nib;
    logic       fin;
  } lcd_nibble_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] mode;
  logic [7:0] char_code;
  logic [1:0] row;
  logic [3:0] col;
  logic       out_valid;
  logic       out_ready;
  logic       reg_select;
  logic [3:0] nibble;
  logic       last;

  lcd_nibble_t expected_nibbles[$];
  logic [5:0]  cursor_count;
  int          errors;
  int          cycles;
  int          stall_left;
  bit          quiet;

  char_lcd_text_sequencer u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .char_code  (char_code),
    .row        (row),
    .col        (col),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .reg_select (reg_select),
    .nibble     (nibble),
    .last       (last)
  );

  always #5 clk = ~clk;

  // Mostly short gaps, now and then a long one; none while quiet.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] glyph_source(input int k);
    case (k)
      0: return 8'hA4;
      1: return 8'h84;
      2: return 8'hB6;
      3: return 8'h96;
      4: return 8'hBC;
      5: return 8'h9C;
      6: return 8'h9F;
      7: return 8'hB0;
      default: return 8'hB5;
    endcase
  endfunction

  function automatic void queue_byte(input logic rs, input logic [7:0] b, input logic fin);
    expected_nibbles.push_back({rs, b[7:4], 1'b0});
    expected_nibbles.push_back({rs, b[3:0], fin});
  endfunction

  // Advance the cursor model and queue the nibbles one item produces.
  function automatic void predict_lcd_bytes(input logic [1:0] m, input logic [7:0] ch,
                                            input logic [1:0] r, input logic [3:0] c);
    int         cnt;
    logic       line2;
    logic [7:0] glyph;
    case (m)
      MODE_WRITE: begin
        cnt = cursor_count;
        if (ch == CHAR_NEWLINE)
          cnt = (cnt >= COLS && cnt < 2 * COLS) ? 2 * COLS : COLS;
        if (cnt == COLS) begin
          queue_byte(RS_CMD, CMD_SET_ADDR | LINE2_OFFSET, 1'b0);
        end else if (cnt >= 2 * COLS) begin
          queue_byte(RS_CMD, CMD_CLEAR, 1'b0);
          queue_byte(RS_CMD, CMD_SET_ADDR, 1'b0);
          cnt = 0;
        end
        case (ch)
          8'hA4, 8'h84: glyph = 8'hE1;
          8'hB6, 8'h96: glyph = 8'hEF;
          8'hBC, 8'h9C: glyph = 8'hF5;
          8'h9F:        glyph = 8'hE2;
          8'hB0:        glyph = 8'hDF;
          8'hB5:        glyph = 8'hE4;
          default:      glyph = ch;
        endcase
        queue_byte(RS_DATA, glyph, 1'b1);
        cursor_count = 6'(cnt + 1);
      end
      MODE_GOTO: begin
        line2 = (r != 2'd0);
        queue_byte(RS_CMD, CMD_SET_ADDR | (line2 ? LINE2_OFFSET : 8'h00) | {4'h0, c}, 1'b1);
        cursor_count = 6'((line2 ? COLS : 0) + c);
      end
      MODE_CLEAR: begin
        cursor_count = '0;
        queue_byte(RS_CMD, CMD_CLEAR, 1'b1);
      end
      default: ;
    endcase
  endfunction

  function automatic void flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  // Called and returns just after a rising edge; holds valid high after acceptance.
  task automatic send_item(input logic [1:0] m, input logic [7:0] ch,
                           input logic [1:0] r, input logic [3:0] c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    mode      <= m;
    char_code <= ch;
    row       <= r;
    col       <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_lcd_bytes(m, ch, r, c);
  endtask

  // Drop valid and hold until every queued nibble has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_nibbles.size() != 0) @(posedge clk);
  endtask

  task automatic test_goto_clear();
    send_item(MODE_CLEAR, 8'h00, 2'd0, 4'd0);
    send_item(MODE_GOTO, 8'hFF, 2'd0, 4'd0);
    send_item(MODE_GOTO, 8'h00, 2'd3, 4'd15);
    send_item(MODE_GOTO, 8'h5A, 2'd2, 4'd0);
    send_item(MODE_WRITE, 8'hFF, 2'd0, 4'd0);
  endtask

  task automatic test_line_wrap();
    // last column of line 2, then the screen wrap on the second write
    send_item(MODE_GOTO, 8'h00, 2'd1, 4'd15);
    send_item(MODE_WRITE, 8'h41, 2'd0, 4'd0);
    send_item(MODE_WRITE, 8'h00, 2'd0, 4'd0);
    // newline on line 1 jumps to line 2, on line 2 clears the screen
    send_item(MODE_WRITE, CHAR_NEWLINE, 2'd0, 4'd0);
    send_item(MODE_WRITE, CHAR_NEWLINE, 2'd0, 4'd0);
    send_item(MODE_GOTO, 8'h00, 2'd1, 4'd15);
    send_item(MODE_WRITE, CHAR_NEWLINE, 2'd3, 4'd15);
  endtask

  task automatic test_glyph_remap();
    for (int k = 0; k < 9; k++)
      send_item(MODE_WRITE, glyph_source(k), 2'd0, 4'd0);
    send_item(MODE_WRITE, 8'hA5, 2'd0, 4'd0);
  endtask

  task automatic test_unused_mode();
    send_item(MODE_UNUSED, 8'hFF, 2'd3, 4'd15);
    send_item(MODE_UNUSED, 8'h00, 2'd0, 4'd0);
    send_item(MODE_WRITE, 8'h7E, 2'd0, 4'd0);
  endtask

  task automatic test_random_traffic(input int n_items);
    int         counted;
    int         r;
    logic [1:0] m;
    logic [7:0] ch;
    for (int ph = 0; ph < 4; ph++) begin
      quiet   = (ph == 2);
      counted = 0;
      while (counted < n_items / 4) begin
        r  = $urandom_range(0, 99);
        ch = 8'($urandom_range(0, 255));
        if (r < 6) begin
          m = MODE_UNUSED;
        end else if (r < 14) begin
          m = MODE_CLEAR;
        end else if (r < 30) begin
          m = MODE_GOTO;
        end else begin
          m = MODE_WRITE;
          r = $urandom_range(0, 99);
          if (r < 12) ch = CHAR_NEWLINE;
          else if (r < 27) ch = glyph_source($urandom_range(0, 8));
        end
        send_item(m, ch, 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
        counted++;
      end
      if (ph == 0) wait_drained();
    end
    quiet = 1'b0;
  endtask

  // Output side: random stalls on out_ready, then check each accepted nibble.
  always @(posedge clk) begin : check_nibbles
    lcd_nibble_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_nibbles.size() == 0) begin
        flag_error($sformatf("unexpected nibble rs %0b nibble %h last %0b",
                             reg_select, nibble, last));
      end else begin
        want = expected_nibbles.pop_front();
        if (reg_select !== want.rs || nibble !== want.nib || last !== want.fin)
          flag_error($sformatf("got rs %0b nibble %h last %0b, expected rs %0b nibble %h last %0b",
                               reg_select, nibble, last, want.rs, want.nib, want.fin));
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!quiet && $urandom_range(0, 99) < 30) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    clk          = 1'b0;
    rst          = 1'b1;
    in_valid     = 1'b0;
    mode         = MODE_WRITE;
    char_code    = 8'h00;
    row          = 2'd0;
    col          = 4'd0;
    out_ready    = 1'b0;
    cursor_count = '0;
    errors       = 0;
    cycles       = 0;
    stall_left   = 0;
    quiet        = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_goto_clear();
    test_line_wrap();
    test_glyph_remap();
    test_unused_mode();
    test_random_traffic(396);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_nibbles.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
